### hw/rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned HALF_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BCNT_W   = 4;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd10;
  localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_STOP_A    = 4'd3,
    PH_STOP_B    = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_HIGH   = 4'd6,
    PH_WACK_LOW  = 4'd7,
    PH_WACK_HIGH = 4'd8,
    PH_WACK_TAIL = 4'd9,
    PH_RD_LOW    = 4'd10,
    PH_RD_HIGH   = 4'd11,
    PH_RACK_LOW  = 4'd12,
    PH_RACK_HIGH = 4'd13
  } phase_t;

  // one result word
  typedef struct packed {
    logic              ack;
    logic [BYTE_W-1:0] rx;
    logic              done;
    logic              busy;
    logic              sda;
    logic              scl;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/i2cm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Phase sequencer, bit counter, shift register and half-period counter.
// State moves one tick whenever step is high; res is that tick's result.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic                        cmd_valid,
  input  wire i2cm_pkg::req_t              req_type,
  input  wire logic [i2cm_pkg::BYTE_W-1:0] tx_byte,
  input  wire logic                        send_ack,
  input  wire logic                        sda_in,
  input  wire logic [i2cm_pkg::HALF_W-1:0] half_period,
  output i2cm_pkg::res_t                   res,
  output logic                             cur_busy
);
  import i2cm_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [BCNT_W-1:0]   bcnt_r, bcnt_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [HALF_W-1:0]   tick_r, tick_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  logic                ack_r, ack_nxt;
  logic                pack_r, pack_nxt;
  logic [BYTE_W-1:0]   rxb_r, rxb_nxt;
  logic                done;

  logic [HALF_W-1:0]   half_eff;
  logic [HALF_W-1:0]   tick_inc;
  logic                expire;
  logic [BYTE_W-1:0]   shl;
  logic [BCNT_W-1:0]   bcnt_inc;

  assign half_eff = (half_period == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : half_period;
  assign tick_inc = tick_r + {{(HALF_W-1){1'b0}}, 1'b1};
  assign expire   = (tick_inc >= half_eff);
  assign shl      = {shift_r[BYTE_W-2:0], 1'b0};
  assign bcnt_inc = bcnt_r + {{(BCNT_W-1){1'b0}}, 1'b1};
  assign cur_busy = (phase_r != PH_IDLE);

  // next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    pack_nxt  = pack_r;
    rxb_nxt   = rxb_r;
    done      = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (cmd_valid) begin
        tick_nxt = '0;
        bcnt_nxt = '0;
        unique case (req_type)
          REQ_START: begin
            phase_nxt = PH_START_A; scl_nxt = 1'b1; sda_nxt = 1'b1;
          end
          REQ_STOP: begin
            phase_nxt = PH_STOP_A; scl_nxt = 1'b1; sda_nxt = 1'b0;
          end
          REQ_WRITE: begin
            shift_nxt = tx_byte;
            phase_nxt = PH_WR_LOW; scl_nxt = 1'b0; sda_nxt = tx_byte[BYTE_W-1];
          end
          default: begin
            shift_nxt = '0;
            pack_nxt  = send_ack;
            phase_nxt = PH_RD_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
          end
        endcase
      end
    end else begin
      tick_nxt = tick_inc;
      if (expire) begin
        tick_nxt = '0;
        unique case (phase_r)
          PH_START_A: begin phase_nxt = PH_START_B; scl_nxt = 1'b1; sda_nxt = 1'b0; end
          PH_START_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
          end
          PH_STOP_A: begin phase_nxt = PH_STOP_B; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_STOP_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_WR_LOW: begin phase_nxt = PH_WR_HIGH; scl_nxt = 1'b1; end
          PH_WR_HIGH: begin
            shift_nxt = shl;
            bcnt_nxt  = bcnt_inc;
            scl_nxt   = 1'b0;
            if (bcnt_inc >= BITS_PER_BYTE) begin
              phase_nxt = PH_WACK_LOW; sda_nxt = 1'b1;
            end else begin
              phase_nxt = PH_WR_LOW; sda_nxt = shl[BYTE_W-1];
            end
          end
          PH_WACK_LOW: begin phase_nxt = PH_WACK_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_WACK_HIGH: begin
            ack_nxt = sda_in;
            phase_nxt = PH_WACK_TAIL; scl_nxt = 1'b0; sda_nxt = 1'b1;
          end
          PH_WACK_TAIL: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_RD_LOW: begin phase_nxt = PH_RD_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_RD_HIGH: begin
            shift_nxt = {shift_r[BYTE_W-2:0], sda_in};
            bcnt_nxt  = bcnt_inc;
            scl_nxt   = 1'b0;
            if (bcnt_inc >= BITS_PER_BYTE) begin
              phase_nxt = PH_RACK_LOW; sda_nxt = ~pack_r;
            end else begin
              phase_nxt = PH_RD_LOW; sda_nxt = 1'b1;
            end
          end
          PH_RACK_LOW: begin phase_nxt = PH_RACK_HIGH; scl_nxt = 1'b1; end
          PH_RACK_HIGH: begin
            rxb_nxt = shift_r;
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b1; done = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res.scl  = scl_nxt;
    res.sda  = sda_nxt;
    res.busy = (phase_nxt != PH_IDLE);
    res.done = done;
    res.rx   = rxb_nxt;
    res.ack  = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bcnt_r  <= '0;
      shift_r <= '0;
      tick_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      pack_r  <= 1'b0;
      rxb_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      shift_r <= shift_nxt;
      tick_r  <= tick_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      pack_r  <= pack_nxt;
      rxb_r   <= rxb_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// Open-drain I2C master bit engine, one timing tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one tick: an optional command (start, stop, write
//   byte, read byte) plus the sampled SDA level. Every accepted word yields
//   exactly one result word with the SCL/SDA levels to drive, busy, done,
//   the last received byte and the last write acknowledge.
//   Commands offered while busy are ignored. cfg_we/cfg_wdata set the SCL
//   half period in ticks (reset 10, zero acts as one); write it while idle.
//   Registered result, valid the cycle after input accept. Throughput: one
//   word per cycle while out_tready holds, set by the single engine step
//   feeding the result register; in_tready stays high while the result
//   register is empty or being drained.
//   Reset: engine idle, SCL and SDA released, no result pending.
//   Receiver stall: the result word holds; one new input is taken only as
//   the held word leaves, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [i2cm_pkg::HALF_W-1:0]      cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
  input  wire logic [i2cm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd_valid[0], req_type[2:1]
  input  wire logic [i2cm_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
  // ack_received[12], zero fill
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import i2cm_pkg::*;

  logic [HALF_W-1:0] half_r;
  logic              out_valid_r;
  res_t              out_data_r;
  res_t              res;
  logic              in_fire;
  logic              eng_busy;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .cmd_valid   (in_tuser[0]),
    .req_type    (req_t'(in_tuser[2:1])),
    .tx_byte     (in_tdata[7:0]),
    .send_ack    (in_tdata[8]),
    .sda_in      (in_tdata[9]),
    .half_period (half_r),
    .res         (res),
    .cur_busy    (eng_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
    end else if (cfg_we) begin
      half_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(res_t)){1'b0}}, out_data_r};

  // done only ends a command that was running, and leaves the engine idle
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.done) |-> eng_busy)
    else $error("done without a running command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.done) |-> !res.busy)
    else $error("busy still set on done tick");

  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !eng_busy && !in_tuser[0]) |-> (!res.busy && !res.done))
    else $error("idle engine left idle without a command");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
